>>> rtl/acr_pkg.sv
package acr_pkg;

  // command codes on s_tuser
  localparam logic [1:0] CMD_RX      = 2'd0;
  localparam logic [1:0] CMD_RESOLVE = 2'd1;
  localparam logic [1:0] CMD_KICK    = 2'd2;

  // arp operation codes
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [1:0]  SEND_NONE      = 2'd0;
  localparam logic [1:0]  SEND_REQUEST   = 2'd1;
  localparam logic [1:0]  SEND_REPLY     = 2'd2;

  localparam logic [15:0] MIN_FRAME  = 16'd42;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [7:0]  IPV4_LEN   = 8'd4;
  localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;

  // register address width and the select values on paddr[3]
  localparam int unsigned APB_AW = 4;
  localparam logic        REG_OWN_MAC = 1'b0;
  localparam logic        REG_OWN_IP  = 1'b1;

  // input item payload, last field in the lowest bits
  typedef struct packed {
    logic [31:0] query_ip;
    logic [31:0] target_ip;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [15:0] operation;
    logic [7:0]  proto_addr_len;
    logic [15:0] proto_type;
    logic [15:0] frame_length;
  } in_data_t;

  localparam int unsigned IN_DATA_W = $bits(in_data_t);

  // result payload
  typedef struct packed {
    logic [31:0] reply_target_ip;
    logic [47:0] reply_target_mac;
    logic [47:0] dest_mac;
    logic [47:0] resolved_mac;
  } out_data_t;

  typedef struct packed {
    logic [1:0] send_oper;
    logic       send_packet;
    logic       resolve_hit;
  } out_user_t;

  localparam int unsigned OUT_DATA_W = $bits(out_data_t);
  localparam int unsigned OUT_USER_W = $bits(out_user_t);

  // one cache entry as held in the ram
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/acr_ram.sv
module acr_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/arp_cache_responder.sv
// channel   direction  handshake          payload
// s_        in         s_tvalid/s_tready  s_tdata packet fields, s_tuser command
// m_        out        m_tvalid/m_tready  m_tdata addresses, m_tuser hit/send flags
// apb       in         psel/penable       own_mac at 0x0, own_ip at 0x8
//
// a resolve or a received packet scans the cache one entry a cycle through the
// ram read port, ending early on a hit; a kick goes straight to the emit state,
// and dropped packets and unused commands are taken without leaving idle
// synchronous active-high reset clears the valid bits, the registers and control
// a result waits in the output register; the next item is taken meanwhile and
// its own result waits in the emit state until the output register is free
module arp_cache_responder #(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // frame_length, proto_type, proto_addr_len, operation, sender_mac,
  // sender_ip, target_ip, query_ip (lowest bit first)
  input  logic [acr_pkg::IN_DATA_W-1:0]       s_tdata,
  // command
  input  logic [1:0]                          s_tuser,
  // result items
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // resolved_mac, dest_mac, reply_target_mac, reply_target_ip (lowest bit first)
  output logic [acr_pkg::OUT_DATA_W-1:0]      m_tdata,
  // resolve_hit, send_packet, send_oper (lowest bit first)
  output logic [acr_pkg::OUT_USER_W-1:0]      m_tuser,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [acr_pkg::APB_AW-1:0]          paddr,
  input  logic [63:0]                         pwdata,
  output logic [63:0]                         prdata,
  output logic                                pready
);

  import acr_pkg::*;

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    out_user_t user;
    out_data_t data;
  } result_t;

  state_t state;

  // configuration registers
  logic [47:0] own_mac;
  logic [31:0] own_ip;

  // item context captured at accept
  logic [31:0] key_ip;        // sender ip when learning, query ip when resolving
  logic [47:0] key_mac;
  logic        is_learn;
  logic        want_reply;

  // scan control
  logic [IDX_W-1:0] scan_idx;   // address being issued
  logic             issue_done;
  logic             cmp_vld;    // ram data for cmp_idx is on rd_data
  logic [IDX_W-1:0] cmp_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic [CACHE_ENTRIES-1:0] valid;

  result_t res;       // pending result
  result_t out_reg;

  in_data_t s_data;
  entry_t   rd_data;
  entry_t   wr_data;
  logic     wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic     rd_en;
  logic     cmp_hit;
  logic     cmp_end;
  logic     free_here;
  logic     apb_wr;

  assign s_data   = in_data_t'(s_tdata);
  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = out_reg.data;
  assign m_tuser  = out_reg.user;
  assign pready   = 1'b1;
  assign apb_wr   = psel && penable && pwrite;

  always_comb begin
    prdata = (paddr[3] == REG_OWN_IP) ? {32'd0, own_ip} : {16'd0, own_mac};
  end

  // compare the entry read last cycle; the first free slot is tracked on the way
  always_comb begin
    cmp_hit   = cmp_vld && valid[cmp_idx] && (rd_data.ip == key_ip);
    cmp_end   = cmp_vld && !cmp_hit && (cmp_idx == LAST_IDX);
    free_here = cmp_vld && !valid[cmp_idx];
    rd_en     = (state == ST_SCAN) && !issue_done;
    wr_en     = (state == ST_SCAN) && is_learn && (cmp_hit || cmp_end);
    if (cmp_hit) begin
      wr_addr = cmp_idx;
    end else if (free_found) begin
      wr_addr = free_idx;
    end else if (free_here) begin
      wr_addr = cmp_idx;
    end else begin
      wr_addr = '0;   // cache full: overwrite slot 0
    end
    wr_data.ip  = key_ip;
    wr_data.mac = key_mac;
  end

  acr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_cache (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      own_mac    <= '0;
      own_ip     <= '0;
      valid      <= '0;
      m_tvalid   <= 1'b0;
      issue_done <= 1'b0;
      cmp_vld    <= 1'b0;
      free_found <= 1'b0;
      scan_idx   <= '0;
    end else begin
      if (apb_wr) begin
        if (paddr[3] == REG_OWN_MAC) begin
          own_mac <= pwdata[47:0];
        end else begin
          own_ip <= pwdata[31:0];
        end
      end

      // the emit state reloads the output register itself
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          scan_idx   <= '0;
          issue_done <= 1'b0;
          cmp_vld    <= 1'b0;
          free_found <= 1'b0;
          if (s_tvalid) begin
            key_mac    <= s_data.sender_mac;
            want_reply <= (s_data.operation == ARP_OP_REQUEST) &&
                          (s_data.target_ip == own_ip) && (own_ip != '0);
            case (s_tuser)
              CMD_RX: begin
                is_learn <= 1'b1;
                key_ip   <= s_data.sender_ip;
                if ((s_data.frame_length >= MIN_FRAME) &&
                    (s_data.proto_type == PROTO_IPV4) &&
                    (s_data.proto_addr_len == IPV4_LEN)) begin
                  state <= ST_SCAN;
                end
              end
              CMD_RESOLVE: begin
                is_learn <= 1'b0;
                key_ip   <= s_data.query_ip;
                state    <= ST_SCAN;
              end
              CMD_KICK: begin
                // gratuitous request, sent even while own ip is zero
                res.user.resolve_hit       <= 1'b0;
                res.user.send_packet       <= 1'b1;
                res.user.send_oper         <= SEND_REQUEST;
                res.data.resolved_mac      <= '0;
                res.data.dest_mac          <= BCAST_MAC;
                res.data.reply_target_mac  <= '0;
                res.data.reply_target_ip   <= own_ip;
                state                      <= ST_EMIT;
              end
              default: begin
                // unused command is dropped
              end
            endcase
          end
        end

        ST_SCAN: begin
          // issue one read address a cycle
          cmp_vld <= !issue_done && !(cmp_hit || cmp_end);
          cmp_idx <= scan_idx;
          if (!issue_done) begin
            if (scan_idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + IDX_W'(1);
            end
          end
          if (free_here && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end

          if (cmp_hit || cmp_end) begin
            if (is_learn) begin
              valid[wr_addr]             <= 1'b1;
              res.user.resolve_hit       <= 1'b0;
              res.user.send_packet       <= 1'b1;
              res.user.send_oper         <= SEND_REPLY;
              res.data.resolved_mac      <= '0;
              res.data.dest_mac          <= key_mac;
              res.data.reply_target_mac  <= key_mac;
              res.data.reply_target_ip   <= key_ip;
              state                      <= want_reply ? ST_EMIT : ST_IDLE;
            end else if (cmp_hit) begin
              res.user.resolve_hit       <= 1'b1;
              res.user.send_packet       <= 1'b0;
              res.user.send_oper         <= SEND_NONE;
              res.data.resolved_mac      <= rd_data.mac;
              res.data.dest_mac          <= '0;
              res.data.reply_target_mac  <= '0;
              res.data.reply_target_ip   <= '0;
              state                      <= ST_EMIT;
            end else begin
              // miss: broadcast a request for the queried address
              res.user.resolve_hit       <= 1'b0;
              res.user.send_packet       <= 1'b1;
              res.user.send_oper         <= SEND_REQUEST;
              res.data.resolved_mac      <= '0;
              res.data.dest_mac          <= BCAST_MAC;
              res.data.reply_target_mac  <= '0;
              res.data.reply_target_ip   <= key_ip;
              state                      <= ST_EMIT;
            end
          end
        end

        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_reg  <= res;
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
